### hw/rtl/lpmd_pkg.sv
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared types and constants for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

   localparam int LEN_DIGITS_DEFAULT = 3;

   localparam int ACC_W = 10;
   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   localparam logic [7:0] CHAR_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE = 8'h5D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_SKIP = 2'd2,
      PH_DATA = 2'd3
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      logic       last_of_message;
      logic       empty_message;
   } result_type;

endpackage

### hw/rtl/lpmd_parse.sv
// ----------------------------------------------------------------------------
// lpmd_parse
// Input register and frame state machine; one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module lpmd_parse #(
   parameter int LEN_DIGITS = lpmd_pkg::LEN_DIGITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_in_byte,
   input  logic                  space,
   output lpmd_pkg::result_type  result
);

   localparam int DC_W = $clog2(LEN_DIGITS + 1);
   localparam int ACC_W = lpmd_pkg::ACC_W;
   localparam int MUL_W = ACC_W + 4;

   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff;
   logic             fire;

   lpmd_pkg::phase_type phase_ff, phase_in;
   logic [ACC_W-1:0] accum_ff, accum_in;
   logic [DC_W-1:0]  count_ff, count_in;
   logic             stopped_ff, stopped_in;
   logic [ACC_W-1:0] left_ff, left_in;
   logic             started_ff, started_in;
   logic             negative_ff, negative_in;

   logic             is_digit;
   logic             is_space;
   logic             is_sign;
   logic [MUL_W-1:0] accum_x10;
   logic [ACC_W-1:0] accum_sat;

   assign req_stall = valid_ff && !space;
   assign fire      = valid_ff && space;
   assign valid_in  = req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         byte_ff <= req_in_byte;
      end
   end

   assign is_digit = (byte_ff >= lpmd_pkg::CHAR_ZERO) && (byte_ff <= lpmd_pkg::CHAR_NINE);
   assign is_space = (byte_ff == lpmd_pkg::CHAR_SPACE)
                  || ((byte_ff >= lpmd_pkg::CHAR_TAB) && (byte_ff <= lpmd_pkg::CHAR_CR));
   assign is_sign  = (byte_ff == lpmd_pkg::CHAR_PLUS) || (byte_ff == lpmd_pkg::CHAR_MINUS);

   assign accum_x10 = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                    + {{(MUL_W-4){1'b0}}, byte_ff[3:0]};
   assign accum_sat = (accum_x10 > {{(MUL_W-ACC_W){1'b0}}, lpmd_pkg::ACC_MAX})
                    ? lpmd_pkg::ACC_MAX : accum_x10[ACC_W-1:0];

   // next state
   always_comb begin
      phase_in    = phase_ff;
      accum_in    = accum_ff;
      count_in    = count_ff;
      stopped_in  = stopped_ff;
      left_in     = left_ff;
      started_in  = started_ff;
      negative_in = negative_ff;
      if (fire) begin
         unique case (phase_ff)
            lpmd_pkg::PH_HUNT: begin
               if (byte_ff == lpmd_pkg::CHAR_OPEN) begin
                  phase_in    = lpmd_pkg::PH_LEN;
                  accum_in    = '0;
                  count_in    = '0;
                  stopped_in  = 1'b0;
                  started_in  = 1'b0;
                  negative_in = 1'b0;
               end
            end
            lpmd_pkg::PH_LEN: begin
               priority if (byte_ff == lpmd_pkg::CHAR_CLOSE) begin
                  left_in  = negative_ff ? '0 : accum_ff;
                  phase_in = lpmd_pkg::PH_SKIP;
               end else if (count_ff < DC_W'(LEN_DIGITS)) begin
                  count_in = count_ff + 1'b1;
                  if (!stopped_ff) begin
                     priority if (is_digit) begin
                        accum_in   = accum_sat;
                        started_in = 1'b1;
                     end else if (!started_ff && is_space) begin
                        started_in = started_ff;
                     end else if (!started_ff && is_sign) begin
                        negative_in = (byte_ff == lpmd_pkg::CHAR_MINUS);
                        started_in  = 1'b1;
                     end else begin
                        stopped_in = 1'b1;
                     end
                  end
               end else begin
                  phase_in = lpmd_pkg::PH_HUNT;
                  if (byte_ff == lpmd_pkg::CHAR_OPEN) begin
                     phase_in    = lpmd_pkg::PH_LEN;
                     accum_in    = '0;
                     count_in    = '0;
                     stopped_in  = 1'b0;
                     started_in  = 1'b0;
                     negative_in = 1'b0;
                  end
               end
            end
            lpmd_pkg::PH_SKIP: begin
               phase_in = (left_ff == '0) ? lpmd_pkg::PH_HUNT : lpmd_pkg::PH_DATA;
            end
            lpmd_pkg::PH_DATA: begin
               if (left_ff <= ACC_W'(1)) begin
                  left_in  = '0;
                  phase_in = lpmd_pkg::PH_HUNT;
               end else begin
                  left_in = left_ff - 1'b1;
               end
            end
            default: begin
               phase_in = lpmd_pkg::PH_HUNT;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      result.valid           = 1'b0;
      result.out_byte        = '0;
      result.last_of_message = 1'b0;
      result.empty_message   = 1'b0;
      unique case (phase_ff)
         lpmd_pkg::PH_SKIP: begin
            result.valid           = fire && (left_ff == '0);
            result.last_of_message = 1'b1;
            result.empty_message   = 1'b1;
         end
         lpmd_pkg::PH_DATA: begin
            result.valid           = fire;
            result.out_byte        = byte_ff;
            result.last_of_message = (left_ff <= ACC_W'(1));
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= lpmd_pkg::PH_HUNT;
         accum_ff    <= '0;
         count_ff    <= '0;
         stopped_ff  <= 1'b0;
         left_ff     <= '0;
         started_ff  <= 1'b0;
         negative_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         accum_ff    <= accum_in;
         count_ff    <= count_in;
         stopped_ff  <= stopped_in;
         left_ff     <= left_in;
         started_ff  <= started_in;
         negative_ff <= negative_in;
      end
   end

endmodule

### hw/rtl/lpmd_rsp_buf.sv
// ----------------------------------------------------------------------------
// lpmd_rsp_buf
// Two-entry result buffer; parts the parser from a stalling receiver.
// ----------------------------------------------------------------------------
module lpmd_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  lpmd_pkg::result_type  result,
   output logic                  space,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last_of_message,
   output logic                  rsp_empty_message
);

   logic [9:0] mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign space     = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign push      = result.valid;
   assign pop       = rsp_valid && !rsp_stall;

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= {result.out_byte, result.last_of_message, result.empty_message};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_out_byte        = mem_ff[rd_ptr_ff][9:2];
   assign rsp_last_of_message = mem_ff[rd_ptr_ff][1];
   assign rsp_empty_message   = mem_ff[rd_ptr_ff][0];

endmodule

### hw/rtl/length_prefixed_message_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Strips [nnn] length headers from a byte stream and returns payload bytes.
// ----------------------------------------------------------------------------
// The req channel carries one raw stream byte per transfer; the rsp channel
// carries one payload byte per transfer with a last-of-message flag, or a
// single transfer flagged empty for a zero-length frame. Both channels use
// valid/stall: a transfer completes on a rising edge with valid high and
// stall low.
// A result is formed from the byte in the input register and written into the
// result buffer, from which rsp presents it; a full buffer holds the byte back.
// Throughput: one byte per cycle while the result buffer has space, set by the
// frame state update between the input register and the result buffer.
// Header, bracket and padding bytes are consumed and give no result.
// Reset (synchronous, active high) empties the input register and the
// result buffer and returns the parser to hunting for an opening bracket.
// When the receiver stalls, the two-entry result buffer absorbs results; once
// it is full, req_stall is raised while a byte waits in the input register.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer #(
   parameter int LEN_DIGITS = lpmd_pkg::LEN_DIGITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_message,
   output logic       rsp_empty_message
);

   lpmd_pkg::result_type result;
   logic                 space;

   lpmd_parse #(
      .LEN_DIGITS (LEN_DIGITS)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .space       (space),
      .result      (result)
   );

   lpmd_rsp_buf u_rsp_buf (
      .clock               (clock),
      .reset               (reset),
      .result              (result),
      .space               (space),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_last_of_message (rsp_last_of_message),
      .rsp_empty_message   (rsp_empty_message)
   );

endmodule
